>>> rtl/npsched_pkg.sv
// Shared types and constants for the nonpreemptive priority scheduler.
// Holds the job table sizing, the channel payload structs and the back-end state codes.
// No dependencies.
package npsched_pkg;

    localparam int MAX_PROCS   = 16;
    localparam int IDX_W       = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
    localparam int CNT_W       = $clog2(MAX_PROCS + 1);

    localparam int ARR_W       = 16;
    localparam int BURST_W     = 16;
    localparam int PRIO_W      = 8;
    localparam int TIME_W      = 22;
    localparam int SUM_W       = 26;
    localparam int ID_W        = 5;

    localparam logic [TIME_W-1:0] TIME_MAX = '1;
    localparam logic [SUM_W-1:0]  SUM_MAX  = '1;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [ARR_W-1:0]   arrival_time;
        logic [BURST_W-1:0] burst_time;
        logic [PRIO_W-1:0]  priority_req;
        logic               last_job;
    } in_item_t;

    typedef struct packed {
        logic [TIME_W-1:0] seg_start;
        logic [TIME_W-1:0] seg_end;
        logic [ID_W-1:0]   job_id;
        logic              is_idle;
        logic [TIME_W-1:0] turnaround;
        logic [TIME_W-1:0] waiting;
        logic              is_summary;
        logic [SUM_W-1:0]  total_turnaround;
        logic [SUM_W-1:0]  total_waiting;
        logic              last_result;
    } out_item_t;

    typedef enum logic [0:0] {
        KIND_LOAD,
        KIND_LOAD_RUN
    } item_kind_t;

    typedef struct packed {
        logic [ARR_W-1:0]   arrival;
        logic [BURST_W-1:0] burst;
        logic [PRIO_W-1:0]  prio;
        item_kind_t         kind;
    } job_entry_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_END,
        ST_TAT,
        ST_WAIT,
        ST_JOB_OUT,
        ST_IDLE_OUT,
        ST_SUM_OUT
    } back_state_t;

endpackage

>>> rtl/npsched_front.sv
// Front end of the scheduler: accepts job words, tags them as load or load-and-run,
// and buffers them in a short queue toward the back end. Depends on npsched_pkg.
module npsched_front (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  npsched_pkg::in_item_t  s_data,
    output logic                   q_valid,
    input  logic                   q_ready,
    output npsched_pkg::job_entry_t q_entry
);

    npsched_pkg::job_entry_t                  fifo_mem_reg [npsched_pkg::QUEUE_DEPTH];
    logic [npsched_pkg::QPTR_W-1:0]           wr_ptr_reg, wr_ptr_next;
    logic [npsched_pkg::QPTR_W-1:0]           rd_ptr_reg, rd_ptr_next;
    logic [npsched_pkg::QCNT_W-1:0]           fill_reg, fill_next;
    npsched_pkg::job_entry_t                  entry_in;
    logic                                     push;
    logic                                     pop;

    assign s_ready = (fill_reg != npsched_pkg::QCNT_W'(npsched_pkg::QUEUE_DEPTH));
    assign q_valid = (fill_reg != '0);
    assign q_entry = fifo_mem_reg[rd_ptr_reg];
    assign push    = s_valid && s_ready;
    assign pop     = q_valid && q_ready;

    // classify: the last word of a batch starts a run
    always_comb begin
        entry_in.arrival = s_data.arrival_time;
        entry_in.burst   = s_data.burst_time;
        entry_in.prio    = s_data.priority_req;
        entry_in.kind    = s_data.last_job ? npsched_pkg::KIND_LOAD_RUN
                                           : npsched_pkg::KIND_LOAD;
    end

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == npsched_pkg::QPTR_W'(npsched_pkg::QUEUE_DEPTH - 1))
                          ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == npsched_pkg::QPTR_W'(npsched_pkg::QUEUE_DEPTH - 1))
                          ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({push, pop})
            2'b10:   fill_next = fill_reg + 1'b1;
            2'b01:   fill_next = fill_reg - 1'b1;
            default: fill_next = fill_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            fifo_mem_reg[wr_ptr_reg] <= entry_in;
        end
    end

endmodule

>>> rtl/npsched_back.sv
// Back end of the scheduler: job table, decision scan, segment arithmetic and the
// result register. Depends on npsched_pkg.
module npsched_back (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    q_valid,
    output logic                    q_ready,
    input  npsched_pkg::job_entry_t q_entry,
    output logic                    m_valid,
    input  logic                    m_ready,
    output npsched_pkg::out_item_t  m_data,
    output logic                    busy
);

    function automatic logic [npsched_pkg::SUM_W-1:0] sum_sat(
        input logic [npsched_pkg::SUM_W-1:0]  acc,
        input logic [npsched_pkg::TIME_W-1:0] val
    );
        logic [npsched_pkg::SUM_W:0] s;
        s = {1'b0, acc} + (npsched_pkg::SUM_W + 1)'(val);
        return s[npsched_pkg::SUM_W] ? npsched_pkg::SUM_MAX : s[npsched_pkg::SUM_W-1:0];
    endfunction

    npsched_pkg::back_state_t           state_reg, state_next;

    logic [npsched_pkg::ARR_W-1:0]      arr_tbl_reg   [npsched_pkg::MAX_PROCS];
    logic [npsched_pkg::BURST_W-1:0]    burst_tbl_reg [npsched_pkg::MAX_PROCS];
    logic [npsched_pkg::PRIO_W-1:0]     prio_tbl_reg  [npsched_pkg::MAX_PROCS];
    logic [npsched_pkg::MAX_PROCS-1:0]  done_reg;

    logic [npsched_pkg::CNT_W-1:0]      count_reg;
    logic [npsched_pkg::CNT_W-1:0]      remaining_reg;
    logic [npsched_pkg::TIME_W-1:0]     cur_time_reg;
    logic [npsched_pkg::SUM_W-1:0]      sum_tat_reg;
    logic [npsched_pkg::SUM_W-1:0]      sum_wt_reg;

    logic [npsched_pkg::IDX_W-1:0]      scan_idx_reg;
    logic                               found_reg;
    logic [npsched_pkg::PRIO_W-1:0]     best_reg;
    logic [npsched_pkg::IDX_W-1:0]      pick_reg;
    logic [npsched_pkg::ARR_W-1:0]      pick_arr_reg;
    logic [npsched_pkg::BURST_W-1:0]    pick_burst_reg;
    logic [npsched_pkg::TIME_W-1:0]     min_arr_reg;
    logic [npsched_pkg::TIME_W-1:0]     end_reg;
    logic [npsched_pkg::TIME_W-1:0]     tat_reg;
    logic [npsched_pkg::TIME_W-1:0]     wt_reg;

    logic                               m_valid_reg;
    npsched_pkg::out_item_t             m_data_reg;
    npsched_pkg::out_item_t             rec_next;

    logic [npsched_pkg::ARR_W-1:0]      scan_arr;
    logic [npsched_pkg::PRIO_W-1:0]     scan_prio;
    logic                               scan_done;
    logic                               scan_ready;
    logic                               scan_take;
    logic                               scan_lower;
    logic                               scan_last;
    logic                               found_next;

    logic                               out_free;
    logic                               load_ok;
    logic [npsched_pkg::CNT_W-1:0]      count_after;
    logic                               pop;
    logic                               run_pop;
    logic                               scan_start;
    logic                               emit_job;
    logic                               emit_idle;
    logic                               emit_sum;
    logic                               last_job_left;

    logic [npsched_pkg::TIME_W:0]       end_sum;
    logic [npsched_pkg::TIME_W-1:0]     end_sat;
    logic [npsched_pkg::TIME_W-1:0]     tat_calc;
    logic [npsched_pkg::TIME_W-1:0]     wt_calc;

    // one table entry per cycle during the scan
    assign scan_arr   = arr_tbl_reg[scan_idx_reg];
    assign scan_prio  = prio_tbl_reg[scan_idx_reg];
    assign scan_done  = done_reg[scan_idx_reg];
    assign scan_ready = !scan_done
                        && (npsched_pkg::TIME_W'(scan_arr) <= cur_time_reg);
    assign scan_take  = scan_ready && (!found_reg || (scan_prio > best_reg));
    assign scan_lower = !scan_done && (npsched_pkg::TIME_W'(scan_arr) < min_arr_reg);
    assign scan_last  = (npsched_pkg::CNT_W'(scan_idx_reg) == (count_reg - 1'b1));
    assign found_next = found_reg || scan_take;

    assign out_free      = !m_valid_reg || m_ready;
    assign load_ok       = (count_reg < npsched_pkg::CNT_W'(npsched_pkg::MAX_PROCS));
    assign count_after   = load_ok ? count_reg + 1'b1 : count_reg;
    assign last_job_left = (remaining_reg == npsched_pkg::CNT_W'(1));

    assign end_sum  = {1'b0, cur_time_reg} + (npsched_pkg::TIME_W + 1)'(pick_burst_reg);
    assign end_sat  = end_sum[npsched_pkg::TIME_W] ? npsched_pkg::TIME_MAX
                                                  : end_sum[npsched_pkg::TIME_W-1:0];
    assign tat_calc = end_reg - npsched_pkg::TIME_W'(pick_arr_reg);
    assign wt_calc  = (tat_reg >= npsched_pkg::TIME_W'(pick_burst_reg))
                      ? tat_reg - npsched_pkg::TIME_W'(pick_burst_reg) : '0;

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            npsched_pkg::ST_IDLE: begin
                if (q_valid && (q_entry.kind == npsched_pkg::KIND_LOAD_RUN)) begin
                    state_next = npsched_pkg::ST_SCAN;
                end
            end
            npsched_pkg::ST_SCAN: begin
                if (scan_last) begin
                    state_next = found_next ? npsched_pkg::ST_END : npsched_pkg::ST_IDLE_OUT;
                end
            end
            npsched_pkg::ST_END:  state_next = npsched_pkg::ST_TAT;
            npsched_pkg::ST_TAT:  state_next = npsched_pkg::ST_WAIT;
            npsched_pkg::ST_WAIT: state_next = npsched_pkg::ST_JOB_OUT;
            npsched_pkg::ST_JOB_OUT: begin
                if (out_free) begin
                    state_next = last_job_left ? npsched_pkg::ST_SUM_OUT : npsched_pkg::ST_SCAN;
                end
            end
            npsched_pkg::ST_IDLE_OUT: begin
                if (out_free) begin
                    state_next = npsched_pkg::ST_SCAN;
                end
            end
            npsched_pkg::ST_SUM_OUT: begin
                if (out_free) begin
                    state_next = npsched_pkg::ST_IDLE;
                end
            end
            default: state_next = npsched_pkg::ST_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        q_ready    = 1'b0;
        emit_job   = 1'b0;
        emit_idle  = 1'b0;
        emit_sum   = 1'b0;
        busy       = 1'b1;
        unique case (state_reg)
            npsched_pkg::ST_IDLE: begin
                q_ready = 1'b1;
                busy    = 1'b0;
            end
            npsched_pkg::ST_JOB_OUT:  emit_job  = out_free;
            npsched_pkg::ST_IDLE_OUT: emit_idle = out_free;
            npsched_pkg::ST_SUM_OUT:  emit_sum  = out_free;
            default: begin
                busy = 1'b1;
            end
        endcase
    end

    assign pop        = q_valid && q_ready;
    assign run_pop    = pop && (q_entry.kind == npsched_pkg::KIND_LOAD_RUN);
    assign scan_start = run_pop || emit_idle || (emit_job && !last_job_left);

    // result record
    always_comb begin
        rec_next = '0;
        if (emit_job) begin
            rec_next.seg_start  = cur_time_reg;
            rec_next.seg_end    = end_reg;
            rec_next.job_id     = npsched_pkg::ID_W'(pick_reg) + 1'b1;
            rec_next.turnaround = tat_reg;
            rec_next.waiting    = wt_reg;
        end else if (emit_idle) begin
            rec_next.seg_start = cur_time_reg;
            rec_next.seg_end   = min_arr_reg;
            rec_next.is_idle   = 1'b1;
        end else begin
            rec_next.seg_end          = cur_time_reg;
            rec_next.is_summary       = 1'b1;
            rec_next.total_turnaround = sum_tat_reg;
            rec_next.total_waiting    = sum_wt_reg;
            rec_next.last_result      = 1'b1;
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= npsched_pkg::ST_IDLE;
            count_reg     <= '0;
            remaining_reg <= '0;
            cur_time_reg  <= '0;
            sum_tat_reg   <= '0;
            sum_wt_reg    <= '0;
            done_reg      <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (pop) begin
                count_reg <= count_after;
                if (load_ok) begin
                    done_reg[count_reg[npsched_pkg::IDX_W-1:0]] <= 1'b0;
                end
                if (run_pop) begin
                    remaining_reg <= count_after;
                    cur_time_reg  <= '0;
                    sum_tat_reg   <= '0;
                    sum_wt_reg    <= '0;
                end
            end
            if (state_reg == npsched_pkg::ST_WAIT) begin
                sum_tat_reg <= sum_sat(sum_tat_reg, tat_reg);
            end
            if (emit_job) begin
                sum_wt_reg         <= sum_sat(sum_wt_reg, wt_reg);
                done_reg[pick_reg] <= 1'b1;
                remaining_reg      <= remaining_reg - 1'b1;
                cur_time_reg       <= end_reg;
            end
            if (emit_idle) begin
                cur_time_reg <= min_arr_reg;
            end
            if (emit_sum) begin
                // drop the batch so a new one can load
                count_reg     <= '0;
                remaining_reg <= '0;
                cur_time_reg  <= '0;
                sum_tat_reg   <= '0;
                sum_wt_reg    <= '0;
                done_reg      <= '0;
            end
            if (emit_job || emit_idle || emit_sum) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // table, scan and datapath registers
    always_ff @(posedge aclk) begin
        if (pop && load_ok) begin
            arr_tbl_reg[count_reg[npsched_pkg::IDX_W-1:0]]   <= q_entry.arrival;
            burst_tbl_reg[count_reg[npsched_pkg::IDX_W-1:0]] <= q_entry.burst;
            prio_tbl_reg[count_reg[npsched_pkg::IDX_W-1:0]]  <= q_entry.prio;
        end
        if (scan_start) begin
            scan_idx_reg <= '0;
            found_reg    <= 1'b0;
            best_reg     <= '0;
            min_arr_reg  <= npsched_pkg::TIME_MAX;
        end
        if (state_reg == npsched_pkg::ST_SCAN) begin
            if (scan_take) begin
                found_reg      <= 1'b1;
                best_reg       <= scan_prio;
                pick_reg       <= scan_idx_reg;
                pick_arr_reg   <= scan_arr;
                pick_burst_reg <= burst_tbl_reg[scan_idx_reg];
            end
            if (scan_lower) begin
                min_arr_reg <= npsched_pkg::TIME_W'(scan_arr);
            end
            if (!scan_last) begin
                scan_idx_reg <= scan_idx_reg + 1'b1;
            end
        end
        if (state_reg == npsched_pkg::ST_END) begin
            end_reg <= end_sat;
        end
        if (state_reg == npsched_pkg::ST_TAT) begin
            tat_reg <= tat_calc;
        end
        if (state_reg == npsched_pkg::ST_WAIT) begin
            wt_reg <= wt_calc;
        end
        if (emit_job || emit_idle || emit_sum) begin
            m_data_reg <= rec_next;
        end
    end

endmodule

>>> rtl/nonpreemptive_priority_scheduler_core.sv
// Top level of the nonpreemptive priority scheduler: front queue plus scheduling back end.
// Depends on npsched_pkg, npsched_front and npsched_back.
//
//   port group   dir  handshake          payload
//   s_*          in   s_valid / s_ready  npsched_pkg::in_item_t  (one job word)
//   m_*          out  m_valid / m_ready  npsched_pkg::out_item_t (idle, job or summary word)
//
// A job word without last_job is stored at the back end when it is popped. A batch
// of N jobs runs up to 2N decisions, each a table scan followed by the END, TAT, WAIT and
// JOB_OUT states for a job segment or IDLE_OUT for an idle one; a summary word ends it.
// Reset is synchronous, active low on aresetn; it clears the queue, counters and done bits.
// The two-entry queue takes two words while a batch runs, then s_ready drops until the batch
// ends; a stall on m_ready holds the back end only when a new result word is due.
module nonpreemptive_priority_scheduler_core (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  npsched_pkg::in_item_t  s_data,
    output logic                   m_valid,
    input  logic                   m_ready,
    output npsched_pkg::out_item_t m_data
);

    // words between front and back
    logic                    q_valid;
    logic                    q_ready;
    npsched_pkg::job_entry_t q_entry;
    logic                    back_busy;

    npsched_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_valid (q_valid),
        .q_ready (q_ready),
        .q_entry (q_entry)
    );

    npsched_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_valid (q_valid),
        .q_ready (q_ready),
        .q_entry (q_entry),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .busy    (back_busy)
    );

    // the back end pops queued words only between batches
    a_pop_when_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (q_valid && q_ready) |-> !back_busy)
        else $error("queue popped while a batch runs");

    // a full front queue always offers a word to the back end
    a_full_offers: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> q_valid)
        else $error("front blocked with empty queue");

    // an idle segment always moves time forward
    a_idle_progress: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.is_idle) |-> (m_data.seg_end > m_data.seg_start))
        else $error("idle segment without progress");

    // a job segment names a job and never waits longer than its turnaround
    a_job_record: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_data.is_idle && !m_data.is_summary)
        |-> ((m_data.job_id != '0) && (m_data.waiting <= m_data.turnaround)))
        else $error("bad job segment");

endmodule

>>> dv/sched_check_pkg.sv
// Scoreboard class for the nonpreemptive priority scheduler testbench.
// Predicts the idle, job and summary words of each batch and checks them in order.
// Depends on npsched_pkg for the word types and table sizing.
package sched_check_pkg;
    import npsched_pkg::*;

    class sched_scoreboard;
        logic [ARR_W-1:0]   arr_tab   [MAX_PROCS];
        logic [BURST_W-1:0] burst_tab [MAX_PROCS];
        logic [PRIO_W-1:0]  prio_tab  [MAX_PROCS];
        int unsigned        loaded;
        out_item_t          records_due [$];
        int unsigned        errors;
        int unsigned        words_checked;

        function new();
            loaded        = 0;
            errors        = 0;
            words_checked = 0;
        endfunction

        // Print one line per mismatch and count it.
        task report(string what);
            errors++;
            $display("MISMATCH (word %0d): %s", words_checked, what);
        endtask

        function void push_record(int unsigned s, int unsigned e, int unsigned id, bit idle,
                                  int unsigned tat, int unsigned wt, bit summ,
                                  int unsigned tt, int unsigned tw);
            out_item_t rec;
            rec                  = '0;
            rec.seg_start        = s[TIME_W-1:0];
            rec.seg_end          = e[TIME_W-1:0];
            rec.job_id           = id[ID_W-1:0];
            rec.is_idle          = idle;
            rec.turnaround       = tat[TIME_W-1:0];
            rec.waiting          = wt[TIME_W-1:0];
            rec.is_summary       = summ;
            rec.total_turnaround = tt[SUM_W-1:0];
            rec.total_waiting    = tw[SUM_W-1:0];
            rec.last_result      = summ;
            records_due.push_back(rec);
        endfunction

        // Store an accepted job word; on last_job, play out the whole batch.
        function void note_job(in_item_t w);
            bit [MAX_PROCS-1:0] done;
            bit                 found;
            int unsigned        now, fin, tat, wt, tot_tat, tot_wt, nxt, pick, best, left;
            if (loaded < MAX_PROCS) begin
                arr_tab[loaded]   = w.arrival_time;
                burst_tab[loaded] = w.burst_time;
                prio_tab[loaded]  = w.priority_req;
                loaded++;
            end
            if (!w.last_job)
                return;
            done    = '0;
            left    = loaded;
            now     = 0;
            tot_tat = 0;
            tot_wt  = 0;
            while (left > 0) begin
                found = 1'b0;
                pick  = 0;
                best  = 0;
                for (int i = 0; i < loaded; i++) begin
                    if (!done[i] && 32'(arr_tab[i]) <= now &&
                        (!found || 32'(prio_tab[i]) > best)) begin
                        found = 1'b1;
                        pick  = i;
                        best  = 32'(prio_tab[i]);
                    end
                end
                if (!found) begin
                    nxt = 32'(TIME_MAX);
                    for (int i = 0; i < loaded; i++)
                        if (!done[i] && 32'(arr_tab[i]) < nxt)
                            nxt = 32'(arr_tab[i]);
                    push_record(now, nxt, 0, 1'b1, 0, 0, 1'b0, 0, 0);
                    now = nxt;
                end else begin
                    fin = now + 32'(burst_tab[pick]);
                    if (fin > 32'(TIME_MAX))
                        fin = 32'(TIME_MAX);
                    tat = fin - 32'(arr_tab[pick]);
                    wt  = (tat >= 32'(burst_tab[pick])) ? tat - 32'(burst_tab[pick]) : 0;
                    push_record(now, fin, pick + 1, 1'b0, tat, wt, 1'b0, 0, 0);
                    done[pick] = 1'b1;
                    left--;
                    now     = fin;
                    tot_tat = tot_tat + tat;
                    tot_wt  = tot_wt + wt;
                    if (tot_tat > 32'(SUM_MAX))
                        tot_tat = 32'(SUM_MAX);
                    if (tot_wt > 32'(SUM_MAX))
                        tot_wt = 32'(SUM_MAX);
                end
            end
            push_record(0, now, 0, 1'b0, 0, 0, 1'b1, tot_tat, tot_wt);
            loaded = 0;
        endfunction

        task check_field(string name, logic [31:0] got, logic [31:0] want);
            if (got !== want)
                report($sformatf("%s got %0h want %0h", name, got, want));
        endtask

        // Compare one accepted result word against the oldest prediction.
        task check_record(out_item_t r);
            out_item_t want;
            if (records_due.size() == 0) begin
                report($sformatf("unexpected word %h", r));
            end else begin
                want = records_due.pop_front();
                check_field("seg_start", 32'(r.seg_start), 32'(want.seg_start));
                check_field("seg_end", 32'(r.seg_end), 32'(want.seg_end));
                check_field("job_id", 32'(r.job_id), 32'(want.job_id));
                check_field("is_idle", 32'(r.is_idle), 32'(want.is_idle));
                check_field("turnaround", 32'(r.turnaround), 32'(want.turnaround));
                check_field("waiting", 32'(r.waiting), 32'(want.waiting));
                check_field("is_summary", 32'(r.is_summary), 32'(want.is_summary));
                check_field("total_turnaround", 32'(r.total_turnaround),
                            32'(want.total_turnaround));
                check_field("total_waiting", 32'(r.total_waiting), 32'(want.total_waiting));
                check_field("last_result", 32'(r.last_result), 32'(want.last_result));
            end
            words_checked++;
        endtask
    endclass

endpackage

>>> dv/testbench.sv
// Top-level testbench for nonpreemptive_priority_scheduler_core.
// Drives directed and random job batches with random idling on both channels and
// checks every result word through sched_check_pkg; depends on npsched_pkg too.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import npsched_pkg::*;
    import sched_check_pkg::*;

    localparam int HALF_PERIOD  = 6;
    localparam int RESET_CYCLES = 7;
    localparam int JOB_TARGET   = 420;    // stop starting batches after this many job words
    localparam int TAIL_JOBS    = 60;     // last stretch runs without idling
    localparam int HOLD_AFTER   = 40;     // start the long receiver hold-off after this word
    localparam int HOLD_CYCLES  = 600;
    localparam int DRAIN_CYCLES = 60;
    localparam int CYCLE_LIMIT  = 400000;

    logic      aclk = 1'b0;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    in_item_t  s_data;
    logic      m_valid;
    logic      m_ready;
    out_item_t m_data;

    sched_scoreboard sb;
    int unsigned     jobs_sent = 0;
    int unsigned     gap_odds  = 0;      // percent chance of a sender gap after each word
    bit              tail_phase = 1'b0;
    int unsigned     cycle_count = 0;

    nonpreemptive_priority_scheduler_core dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always #(HALF_PERIOD) aclk = ~aclk;

    // Watchdog: end the run if the block hangs or stalls far beyond any legal run.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Offer one job word and hold it until the block takes it. Valid stays up across
    // back-to-back words; a random gap drops it between words.
    task automatic send_job(input logic [ARR_W-1:0] arr, input logic [BURST_W-1:0] burst,
                            input logic [PRIO_W-1:0] prio, input bit last);
        in_item_t w;
        w.arrival_time = arr;
        w.burst_time   = burst;
        w.priority_req = prio;
        w.last_job     = last;
        s_data  <= w;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        sb.note_job(w);
        jobs_sent++;
        if (jobs_sent >= JOB_TARGET - TAIL_JOBS)
            tail_phase = 1'b1;
        if (!tail_phase && gap_odds != 0 && $urandom_range(0, 99) < gap_odds) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge aclk);
        end
    endtask

    // Build one random batch: mostly small tables, some larger ones up to full, a few that overflow
    // the table so the trailing jobs get dropped. Arrival, burst and priority each pick
    // a style per batch: tight ranges force contention and ties, full ranges hit every bit.
    task automatic run_random_batch();
        int unsigned       n, pick_n, arr_style, burst_style, prio_style;
        logic [PRIO_W-1:0] flat_prio;
        logic [ARR_W-1:0]  a;
        logic [BURST_W-1:0] b;
        logic [PRIO_W-1:0] p;
        pick_n = $urandom_range(0, 19);
        if (pick_n < 12)
            n = $urandom_range(1, 8);
        else if (pick_n < 18)
            n = $urandom_range(9, MAX_PROCS);
        else
            n = $urandom_range(MAX_PROCS + 1, MAX_PROCS + 4);
        arr_style   = $urandom_range(0, 3);
        burst_style = $urandom_range(0, 3);
        prio_style  = $urandom_range(0, 2);
        flat_prio   = PRIO_W'($urandom);
        case ($urandom_range(0, 2))
            0: gap_odds = 0;
            1: gap_odds = 20;
            default: gap_odds = 50;
        endcase
        for (int j = 0; j < n; j++) begin
            case (arr_style)
                0: a = '0;
                1: a = ARR_W'($urandom_range(0, 63));
                2: a = ARR_W'($urandom_range(0, 4095));
                default: a = ARR_W'($urandom);
            endcase
            case (burst_style)
                0: b = BURST_W'($urandom_range(0, 31));
                1: b = BURST_W'($urandom_range(0, 1023));
                2: b = BURST_W'($urandom);
                default: b = ($urandom_range(0, 3) == 0) ? '0 : BURST_W'($urandom_range(0, 15));
            endcase
            case (prio_style)
                0: p = PRIO_W'($urandom_range(0, 3));
                1: p = PRIO_W'($urandom);
                default: p = flat_prio;
            endcase
            send_job(a, b, p, j == n - 1);
        end
    endtask

    // Stimulus: reset, a short directed set of batches, then random batches.
    initial begin : job_source
        sb      = new();
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data  = '0;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Single job, all fields at zero: zero-length segment at time 0.
        send_job('0, '0, '0, 1'b1);
        // Single job at the top of every field: idle up to its arrival, then run.
        send_job('1, '1, '1, 1'b1);
        // Equal priorities resolve by lowest job number; a higher priority arriving
        // mid-run waits for the running job but jumps the queue afterwards.
        send_job(16'd0, 16'd5, 8'd7, 1'b0);
        send_job(16'd0, 16'd3, 8'd7, 1'b0);
        send_job(16'd0, 16'd1, 8'd7, 1'b0);
        send_job(16'd2, 16'd4, 8'd200, 1'b1);
        // CPU goes idle between two jobs.
        send_job(16'd0, 16'd10, 8'd0, 1'b0);
        send_job(16'd100, 16'd5, 8'd255, 1'b1);
        // Fill the table and push one more: the extra job is dropped, but its
        // last_job flag still starts the batch.
        for (int j = 0; j <= MAX_PROCS; j++)
            send_job(ARR_W'(j * 3),
                     (j == 0) ? 16'hFFFF : ((j % 2) ? 16'hAAAA >> 10 : 16'h5555 >> 10),
                     (j % 2) ? 8'hAA : 8'h55, j == MAX_PROCS);

        while (jobs_sent < JOB_TARGET)
            run_random_batch();
        s_valid <= 1'b0;

        // Drain: wait for every predicted word, then watch for strays.
        while (sb.records_due.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (sb.records_due.size() != 0)
            sb.report($sformatf("%0d words never arrived", sb.records_due.size()));
        if (sb.errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // Result side: check each accepted word, then decide ready for the next cycle.
    // Idling runs in modes (none, light, heavy) that switch at random.
    // Once, after HOLD_AFTER words, hold ready low for HOLD_CYCLES so the back end
    // stalls, the front queue fills and s_ready drops while the sender keeps offering.
    initial begin : result_sink
        int unsigned stall_left, mode, mode_left, words_seen;
        bit          hold_done;
        stall_left = 0;
        mode       = 0;
        mode_left  = 0;
        words_seen = 0;
        hold_done  = 1'b0;
        m_ready    = 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) begin
                sb.check_record(m_data);
                words_seen++;
            end
            if (!hold_done && words_seen >= HOLD_AFTER) begin
                hold_done  = 1'b1;
                stall_left = HOLD_CYCLES;
            end else if (stall_left != 0) begin
                stall_left--;
            end else if (!tail_phase) begin
                if (mode_left == 0) begin
                    mode      = $urandom_range(0, 2);
                    mode_left = $urandom_range(20, 80);
                end else begin
                    mode_left--;
                end
                if ((mode == 1 && $urandom_range(0, 7) == 0) ||
                    (mode == 2 && $urandom_range(0, 2) == 0))
                    stall_left = $urandom_range(1, 7);
            end
            m_ready <= (stall_left == 0);
        end
    end

endmodule

>>> filelist.f
rtl/npsched_pkg.sv
rtl/npsched_front.sv
rtl/npsched_back.sv
rtl/nonpreemptive_priority_scheduler_core.sv
dv/sched_check_pkg.sv
dv/testbench.sv
